[hw/rtl/deq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque package
// Shared widths, operation codes and status codes of the ring-buffer deque.
// ----------------------------------------------------------------------------
package deq_pkg;

	localparam int DATA_W    = 32;
	localparam int OP_W      = 3;
	localparam int STATUS_W  = 2;
	localparam int DEPTH_DEF = 16;

	typedef logic [DATA_W-1:0]   data_t;
	typedef logic [OP_W-1:0]     op_t;
	typedef logic [STATUS_W-1:0] status_t;

	// Operation codes; unused codes behave as a query
	localparam op_t OP_PUSH_REAR  = 3'd0;
	localparam op_t OP_PUSH_FRONT = 3'd1;
	localparam op_t OP_POP_REAR   = 3'd2;
	localparam op_t OP_POP_FRONT  = 3'd3;
	localparam op_t OP_CLEAR      = 3'd4;
	localparam op_t OP_QUERY      = 3'd5;

	// Status codes
	localparam status_t ST_DONE  = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_EMPTY = 2'd2;

	// Reported for both ends of an empty queue
	localparam data_t EMPTY_VALUE = '1;

endpackage : deq_pkg
`default_nettype wire

[hw/rtl/deq_mem.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque entry store
// One write port, two read ports, read data registered with write forwarding.
// ----------------------------------------------------------------------------
module deq_mem
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire data_t         wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr_front,
	input  wire logic [AW-1:0] raddr_rear,
	output data_t              rdata_front,
	output data_t              rdata_rear
);

	data_t mem [DEPTH];
	data_t rdata_front_q;
	data_t rdata_rear_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Forward the beat being written when a read hits the same slot
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_front_q <= (we && (waddr == raddr_front)) ? wdata : mem[raddr_front];
			rdata_rear_q  <= (we && (waddr == raddr_rear))  ? wdata : mem[raddr_rear];
		end
	end

	assign rdata_front = rdata_front_q;
	assign rdata_rear  = rdata_rear_q;

endmodule : deq_mem
`default_nettype wire

[hw/rtl/deq_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque controller
// Head and count registers, store write and read addressing, result framing.
// ----------------------------------------------------------------------------
module deq_ctrl
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire op_t           operation,
	input  wire data_t         value,
	output logic               mem_we,
	output logic [AW-1:0]      mem_waddr,
	output data_t              mem_wdata,
	output logic               mem_re,
	output logic [AW-1:0]      mem_raddr_front,
	output logic [AW-1:0]      mem_raddr_rear,
	input  wire data_t         mem_rdata_front,
	input  wire data_t         mem_rdata_rear,
	output logic               done,
	output data_t              front_value,
	output data_t              rear_value,
	output logic [CW-1:0]      count,
	output logic               is_empty,
	output status_t            status
);

	typedef enum logic {
		S_IDLE,
		S_RESP
	} state_t;

	state_t         state_q;
	logic [AW-1:0]  head_q;
	logic [CW-1:0]  cnt_q;
	status_t        status_q;

	logic           accept;
	logic [AW-1:0]  head_nxt;
	logic [CW-1:0]  cnt_nxt;
	logic [CW-1:0]  cnt_m1;
	status_t        status_nxt;
	logic           full;
	logic           empty;

	function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
	                                           input logic [AW-1:0] offs);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, offs};
		if (sum >= (AW+1)'(DEPTH)) begin
			sum = sum - (AW+1)'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] idx);
		return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] idx);
		return (idx == '0) ? AW'(DEPTH - 1) : idx - AW'(1);
	endfunction

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign full   = (cnt_q == CW'(DEPTH));
	assign empty  = (cnt_q == '0);

	always_comb begin
		head_nxt   = head_q;
		cnt_nxt    = cnt_q;
		status_nxt = ST_DONE;
		mem_we     = 1'b0;
		mem_waddr  = ring_add(head_q, cnt_q[AW-1:0]);
		mem_wdata  = value;
		if (accept) begin
			case (operation)
				OP_PUSH_REAR: begin
					if (full) begin
						status_nxt = ST_FULL;
					end else begin
						mem_we  = 1'b1;
						cnt_nxt = cnt_q + CW'(1);
					end
				end
				OP_PUSH_FRONT: begin
					if (full) begin
						status_nxt = ST_FULL;
					end else begin
						head_nxt  = ring_dec(head_q);
						mem_we    = 1'b1;
						mem_waddr = head_nxt;
						cnt_nxt   = cnt_q + CW'(1);
					end
				end
				OP_POP_REAR: begin
					if (empty) begin
						status_nxt = ST_EMPTY;
					end else begin
						cnt_nxt = cnt_q - CW'(1);
					end
				end
				OP_POP_FRONT: begin
					if (empty) begin
						status_nxt = ST_EMPTY;
					end else begin
						head_nxt = ring_inc(head_q);
						cnt_nxt  = cnt_q - CW'(1);
					end
				end
				OP_CLEAR: begin
					head_nxt = '0;
					cnt_nxt  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	// Read both ends as they stand after the operation
	assign cnt_m1          = cnt_nxt - CW'(1);
	assign mem_re          = accept;
	assign mem_raddr_front = head_nxt;
	assign mem_raddr_rear  = ring_add(head_nxt, cnt_m1[AW-1:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			head_q   <= '0;
			cnt_q    <= '0;
			status_q <= ST_DONE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						head_q   <= head_nxt;
						cnt_q    <= cnt_nxt;
						status_q <= status_nxt;
						state_q  <= S_RESP;
					end
				end
				S_RESP: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign done        = (state_q == S_RESP);
	assign is_empty    = (cnt_q == '0);
	assign count       = cnt_q;
	assign status      = status_q;
	assign front_value = is_empty ? EMPTY_VALUE : mem_rdata_front;
	assign rear_value  = is_empty ? EMPTY_VALUE : mem_rdata_rear;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("stored count beyond depth");

	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("accepted beat without result next cycle");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_FULL) |-> count == CW'(DEPTH))
		else $error("push dropped while not full");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_EMPTY) |-> is_empty)
		else $error("pop flagged empty on non-empty queue");

endmodule : deq_ctrl
`default_nettype wire

[hw/rtl/double_ended_queue_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded deque of signed 32-bit values held in a ring-buffer store.
// ----------------------------------------------------------------------------
// Pulse start with an operation (push rear, push front, pop rear, pop front,
// clear, query) while busy is low. Each operation runs in two steps: the
// accept edge updates the head and count and writes the pushed value, and
// the store's registered read then delivers both ends, so busy is high for
// the single cycle in which done marks the result beat. The result
// cannot be held off: capture it in the cycle done is high. front_value and
// rear_value read -1 when the queue is empty. A push on a full queue is
// dropped with status 1, a pop on an empty queue is ignored with status 2,
// and clear returns both ends to the first slot. Store contents are not
// cleared at reset and need no clearing pass: only occupied slots are read.
// ----------------------------------------------------------------------------
module double_ended_queue_top
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	output logic               busy,
	input  wire op_t           operation,
	input  wire data_t         value,
	output logic               done,
	output data_t              front_value,
	output data_t              rear_value,
	output logic [CW-1:0]      count,
	output logic               is_empty,
	output status_t            status
);

	// Store port wiring between controller and entry memory
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	data_t         mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr_front;
	logic [AW-1:0] mem_raddr_rear;
	data_t         mem_rdata_front;
	data_t         mem_rdata_rear;

	// Pointer update, addressing and result framing
	deq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.operation       (operation),
		.value           (value),
		.mem_we          (mem_we),
		.mem_waddr       (mem_waddr),
		.mem_wdata       (mem_wdata),
		.mem_re          (mem_re),
		.mem_raddr_front (mem_raddr_front),
		.mem_raddr_rear  (mem_raddr_rear),
		.mem_rdata_front (mem_rdata_front),
		.mem_rdata_rear  (mem_rdata_rear),
		.done            (done),
		.front_value     (front_value),
		.rear_value      (rear_value),
		.count           (count),
		.is_empty        (is_empty),
		.status          (status)
	);

	// Ring storage; forwarding covers a push read back in the same cycle
	deq_mem #(
		.DEPTH (DEPTH)
	) u_mem (
		.clk         (clk),
		.we          (mem_we),
		.waddr       (mem_waddr),
		.wdata       (mem_wdata),
		.re          (mem_re),
		.raddr_front (mem_raddr_front),
		.raddr_rear  (mem_raddr_rear),
		.rdata_front (mem_rdata_front),
		.rdata_rear  (mem_rdata_rear)
	);

endmodule : double_ended_queue_top
`default_nettype wire

[sim/double_ended_queue_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque result checker
// Tracks the deque contents from the accepted command beats and checks every
// result beat, field by field, against the oldest predicted view.
// ----------------------------------------------------------------------------
module double_ended_queue_checker
	import deq_pkg::*;
#(
	parameter int DEPTH = DEPTH_DEF,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          busy,
	input  wire op_t           operation,
	input  wire data_t         value,
	input  wire logic          done,
	input  wire data_t         front_value,
	input  wire data_t         rear_value,
	input  wire logic [CW-1:0] count,
	input  wire logic          is_empty,
	input  wire status_t       status,
	output int                 errors,
	output int                 pending,
	output int                 compared,
	output int                 dropped_pushes,
	output int                 ignored_pops
);

	typedef struct packed {
		data_t         front;
		data_t         rear;
		logic [CW-1:0] fill;
		logic          empty;
		status_t       st;
	} deq_view_t;

	data_t       ring [DEPTH];
	int unsigned head_slot;
	int unsigned fill_level;
	deq_view_t   views [$];
	deq_view_t   want;
	deq_view_t   fresh;

	// Apply one operation to the shadow deque and return the view it leaves
	function automatic deq_view_t apply_op(op_t op, data_t val);
		deq_view_t v;
		v.st = ST_DONE;
		case (op)
			OP_PUSH_REAR, OP_PUSH_FRONT: begin
				if (fill_level == DEPTH) begin
					v.st = ST_FULL;
				end else if (op == OP_PUSH_REAR) begin
					ring[(head_slot + fill_level) % DEPTH] = val;
					fill_level++;
				end else begin
					head_slot = (head_slot + DEPTH - 1) % DEPTH;
					ring[head_slot] = val;
					fill_level++;
				end
			end
			OP_POP_REAR, OP_POP_FRONT: begin
				if (fill_level == 0) begin
					v.st = ST_EMPTY;
				end else begin
					if (op == OP_POP_FRONT)
						head_slot = (head_slot + 1) % DEPTH;
					fill_level--;
				end
			end
			OP_CLEAR: begin
				fill_level = 0;
				head_slot  = 0;
			end
			default: begin
			end
		endcase
		if (fill_level == 0) begin
			v.front = EMPTY_VALUE;
			v.rear  = EMPTY_VALUE;
		end else begin
			v.front = ring[head_slot];
			v.rear  = ring[(head_slot + fill_level - 1) % DEPTH];
		end
		v.fill  = fill_level[CW-1:0];
		v.empty = (fill_level == 0);
		return v;
	endfunction

	task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] got_v);
		if (exp_v !== got_v) begin
			$error("%s mismatch: expected %h, got %h", name, exp_v, got_v);
			errors++;
		end
	endtask

	// Retire the result beat first, then record the command beat of the same edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_slot  = 0;
			fill_level = 0;
			views.delete();
		end else begin
			if (done) begin
				if (views.size() == 0) begin
					$error("result beat with no operation outstanding");
					errors++;
				end else begin
					want = views.pop_front();
					compared++;
					check_field("front_value", want.front, front_value);
					check_field("rear_value", want.rear, rear_value);
					check_field("count", DATA_W'(want.fill), DATA_W'(count));
					check_field("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
					check_field("status", DATA_W'(want.st), DATA_W'(status));
				end
			end
			if (start && !busy) begin
				fresh = apply_op(operation, value);
				if (fresh.st == ST_FULL)
					dropped_pushes++;
				if (fresh.st == ST_EMPTY)
					ignored_pops++;
				views.push_back(fresh);
			end
		end
		pending = views.size();
	end

endmodule : double_ended_queue_checker

[sim/double_ended_queue_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deque testbench
// Drives command beats into the ring-buffer deque: a directed pass over the
// empty and full corners, then random runs leaning towards filling, draining
// or neither, with bursts of idle cycles. A checker beside the block predicts
// and compares every result beat; this module gives the verdict.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;
	import deq_pkg::*;

	localparam int DEPTH        = DEPTH_DEF;
	localparam int CW           = $clog2(DEPTH + 1);
	localparam int CLK_PERIOD   = 10;
	localparam int RESET_CYCLES = 9;
	localparam int RANDOM_ITEMS = 1880;
	// No idling over the final stretch of the random part
	localparam int CALM_TAIL    = 150;
	// Cycles without any beat before the run is abandoned
	localparam int STALL_LIMIT  = 500;
	// Settling cycles after the last result, to catch stray beats
	localparam int TAIL_CYCLES  = 4;

	// Unused operation codes, which must behave as a query
	localparam op_t OP_SPARE_LO = 3'd6;
	localparam op_t OP_SPARE_HI = 3'd7;

	localparam data_t VAL_MIN  = 32'h8000_0000;
	localparam data_t VAL_MAX  = 32'h7FFF_FFFF;
	localparam data_t VAL_ZERO = 32'h0000_0000;
	localparam data_t VAL_ONES = 32'hFFFF_FFFF;

	// Bias of a random run: lean towards pushes, towards pops, or neither
	typedef enum int {LEAN_FILL, LEAN_DRAIN, LEAN_EVEN} lean_t;

	logic          clk       = 1'b0;
	logic          arst_n    = 1'b0;
	logic          start     = 1'b0;
	op_t           operation = OP_QUERY;
	data_t         value     = '0;
	logic          busy;
	logic          done;
	data_t         front_value;
	data_t         rear_value;
	logic [CW-1:0] count;
	logic          is_empty;
	status_t       status;

	int errors;
	int pending;
	int compared;
	int dropped_pushes;
	int ignored_pops;
	int beats_sent = 0;
	int stall_cycles = 0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	double_ended_queue_top #(
		.DEPTH(DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.value(value),
		.done(done),
		.front_value(front_value),
		.rear_value(rear_value),
		.count(count),
		.is_empty(is_empty),
		.status(status)
	);

	double_ended_queue_checker #(
		.DEPTH(DEPTH)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operation(operation),
		.value(value),
		.done(done),
		.front_value(front_value),
		.rear_value(rear_value),
		.count(count),
		.is_empty(is_empty),
		.status(status),
		.errors(errors),
		.pending(pending),
		.compared(compared),
		.dropped_pushes(dropped_pushes),
		.ignored_pops(ignored_pops)
	);

	// Watchdog: any command or result beat restarts the count; abandon the run
	// once the block has sat still for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog expired after %0d quiet cycles", STALL_LIMIT);
				$display("Test completed with failures");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Present one command beat and hold it until the block takes it. Busy is
	// sampled mid-cycle so the accepting edge is known without a race. Called
	// and returning at a rising edge; start stays high into the next beat
	// unless an idle burst is drawn.
	task automatic send_beat(op_t op, data_t val, bit may_idle);
		int gap;
		operation <= op;
		value     <= val;
		start     <= 1'b1;
		do @(negedge clk); while (busy);
		@(posedge clk);
		beats_sent++;
		if (may_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Drop start and hold off until every outstanding result has come back
	task automatic drain_results();
		start <= 1'b0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Mostly random words, with the signed extremes, zero and all ones mixed in
	function automatic data_t pick_value();
		case ($urandom_range(0, 11))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2:       return VAL_ZERO;
			3:       return VAL_ONES;
			default: return data_t'($urandom);
		endcase
	endfunction

	function automatic op_t pick_op(lean_t lean);
		int roll;
		int push_share;
		roll = $urandom_range(0, 99);
		// Rare clears; a sprinkling of queries and the spare codes
		if (roll < 2)
			return OP_CLEAR;
		if (roll < 8)
			return op_t'($urandom_range(OP_QUERY, OP_SPARE_HI));
		push_share = (lean == LEAN_FILL) ? 75 : (lean == LEAN_DRAIN) ? 25 : 50;
		if ($urandom_range(0, 99) < push_share)
			return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
		return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
	endfunction

	initial begin
		lean_t lean;
		int    run_left;
		bit    idle_ok;

		lean     = LEAN_EVEN;
		run_left = 0;
		idle_ok  = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty corners straight after reset
		send_beat(OP_QUERY, pick_value(), 1'b1);
		send_beat(OP_POP_REAR, pick_value(), 1'b1);
		send_beat(OP_POP_FRONT, pick_value(), 1'b1);

		// Fill from both ends with the signed extremes first, then to capacity
		send_beat(OP_PUSH_REAR, VAL_MAX, 1'b1);
		send_beat(OP_PUSH_FRONT, VAL_MIN, 1'b1);
		send_beat(OP_PUSH_REAR, VAL_ZERO, 1'b1);
		send_beat(OP_PUSH_FRONT, VAL_ONES, 1'b1);
		for (int i = 4; i < DEPTH; i++)
			send_beat((i % 2) ? OP_PUSH_FRONT : OP_PUSH_REAR, data_t'($urandom), 1'b1);

		// Full corners: both pushes must be dropped, spare codes change nothing
		send_beat(OP_PUSH_REAR, pick_value(), 1'b1);
		send_beat(OP_PUSH_FRONT, pick_value(), 1'b1);
		send_beat(OP_SPARE_LO, pick_value(), 1'b1);
		send_beat(OP_SPARE_HI, pick_value(), 1'b1);
		send_beat(OP_POP_FRONT, pick_value(), 1'b1);
		send_beat(OP_POP_REAR, pick_value(), 1'b1);

		// Clear on a non-empty deque, then confirm it reads as empty
		send_beat(OP_CLEAR, pick_value(), 1'b1);
		send_beat(OP_QUERY, pick_value(), 1'b1);

		// Random runs; each run picks a lean, and whether it may idle at all
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (run_left == 0) begin
				lean     = lean_t'($urandom_range(LEAN_FILL, LEAN_EVEN));
				run_left = $urandom_range(10, 40);
				idle_ok  = ($urandom_range(0, 3) != 0);
			end
			run_left--;
			// Pause once mid-run until every result is home
			if (i == RANDOM_ITEMS / 2)
				drain_results();
			send_beat(pick_op(lean), pick_value(),
				idle_ok && (i < RANDOM_ITEMS - CALM_TAIL));
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Issued %0d operations; %0d result beats checked", beats_sent, compared);
		$display("Pushes dropped when full: %0d; pops ignored when empty: %0d",
			dropped_pushes, ignored_pops);
		if (errors == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule : double_ended_queue_top_tb
